/* rtl/core/nvsrd_pkg.sv */
// Shared types and constants for the note valve shift register driver.
`default_nettype none

package nvsrd_pkg;

    localparam int NOTE_W = 8;
    localparam int CNT_W  = 7;

    typedef logic [1:0]        t_req_type;
    typedef logic [NOTE_W-1:0] t_note;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic              t_cfg_index;

    localparam t_req_type REQ_NOTE  = 2'd0;
    localparam t_req_type REQ_CLEAR = 2'd1;
    localparam t_req_type REQ_PUSH  = 2'd2;

    localparam t_cfg_index CFG_NOTE_OFFSET = 1'b0;
    localparam t_cfg_index CFG_VALVE_COUNT = 1'b1;

    localparam t_count VALVE_COUNT_RESET = 7'd64;

    // Update request from the top level to the valve store.
    typedef struct packed {
        logic  note_en;
        logic  clear_en;
        t_note note;
    } t_store_req;

    // Serial output and status of the serializer.
    typedef struct packed {
        logic valid;
        logic shift_bit;
        logic shift_strobe;
        logic latch_strobe;
        logic busy;
    } t_ser_out;

endpackage

`default_nettype wire

/* rtl/core/note_valve_shift_register_driver_core.sv */
// Top level of the note valve shift register driver.
//
// The block keeps one open/closed bit per valve and drives an external serial
// shift register. A request is taken at a clock edge where i_start is high and
// o_busy is low. A note request (a note byte below 0x80 opens, 0x80 and above
// closes the valve at the low seven note bits minus note_offset) and a clear
// request give no result; o_busy stays low, so another request may follow in
// the next cycle. A push request snapshots the valve bits and sends them out
// from valve 0 upward, one result per cycle starting the cycle after the push;
// a push gives max(1, count) results, where count is valve_count limited to
// MAX_VALVES, and o_busy is high while the serializer shifts them out. Each
// result is shown for one cycle with o_valid high and the receiver cannot
// stall it. The last result of a push carries o_latch_strobe; with a count of
// zero the push gives one result with only o_latch_strobe set. Configuration
// writes through the i_cfg_* channel are always ready and are meant to be made
// only while the block is idle.
`default_nettype none

module note_valve_shift_register_driver_core import nvsrd_pkg::*; #(
    parameter int MAX_VALVES = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Request channel.
    input  wire logic       i_start,
    output logic            o_busy,
    input  wire t_req_type  i_req_type,
    input  wire t_note      i_note,
    // Result channel.
    output logic            o_valid,
    output logic            o_shift_bit,
    output logic            o_shift_strobe,
    output logic            o_latch_strobe,
    // Configuration write channel.
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire t_cfg_index i_cfg_index,
    input  wire t_count     i_cfg_data
);

    localparam t_count MAX_CNT = t_count'(MAX_VALVES);

    t_count                r_note_offset;
    t_count                r_valve_count;
    t_count                eff_count;
    logic                  accept;
    logic                  push;
    t_store_req            store_req;
    t_ser_out              ser;
    logic [MAX_VALVES-1:0] valve_bits;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note_offset <= '0;
            r_valve_count <= VALVE_COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_NOTE_OFFSET: r_note_offset <= i_cfg_data;
                CFG_VALVE_COUNT: r_valve_count <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    // A count above the number of built valves means all of them.
    assign eff_count = (r_valve_count > MAX_CNT) ? MAX_CNT : r_valve_count;

    assign accept = i_start & ~o_busy;
    assign push   = accept & (i_req_type == REQ_PUSH);

    // Request type 3 is dropped: neither enable is raised and no push starts.
    assign store_req.note_en  = accept & (i_req_type == REQ_NOTE);
    assign store_req.clear_en = accept & (i_req_type == REQ_CLEAR);
    assign store_req.note     = i_note;

    nvsrd_valve_store #(
        .MAX_VALVES (MAX_VALVES)
    ) u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (store_req),
        .i_note_offset (r_note_offset),
        .i_eff_count   (eff_count),
        .o_valve_bits  (valve_bits)
    );

    nvsrd_serializer #(
        .MAX_VALVES (MAX_VALVES)
    ) u_serializer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (push),
        .i_count (eff_count),
        .i_bits  (valve_bits),
        .o_ser   (ser)
    );

    assign o_busy         = ser.busy;
    assign o_valid        = ser.valid;
    assign o_shift_bit    = ser.shift_bit;
    assign o_shift_strobe = ser.shift_strobe;
    assign o_latch_strobe = ser.latch_strobe;

endmodule

`default_nettype wire

/* rtl/core/nvsrd_valve_store.sv */
// Valve state register with note on/off and clear-all updates.
`default_nettype none

module nvsrd_valve_store import nvsrd_pkg::*; #(
    parameter int MAX_VALVES = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_store_req            i_req,
    input  wire logic [CNT_W-1:0]      i_note_offset,
    input  wire t_count                i_eff_count,
    output logic [MAX_VALVES-1:0]      o_valve_bits
);

    logic [MAX_VALVES-1:0] r_valve_bits;
    logic [MAX_VALVES-1:0] n_valve_bits;
    logic [NOTE_W-1:0]     idx;
    logic                  hit;
    logic                  turn_on;

    // The off flag is masked before the offset is subtracted; wraps at 8 bits.
    assign idx     = {1'b0, i_req.note[NOTE_W-2:0]} - {1'b0, i_note_offset};
    assign hit     = idx < {1'b0, i_eff_count};
    assign turn_on = ~i_req.note[NOTE_W-1];

    always_comb begin
        n_valve_bits = r_valve_bits;
        if (i_req.clear_en) begin
            n_valve_bits = '0;
        end else if (i_req.note_en && hit) begin
            for (int i = 0; i < MAX_VALVES; i++) begin
                if (idx == NOTE_W'(i)) begin
                    n_valve_bits[i] = turn_on;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valve_bits <= '0;
        end else begin
            r_valve_bits <= n_valve_bits;
        end
    end

    assign o_valve_bits = r_valve_bits;

endmodule

`default_nettype wire

/* rtl/core/nvsrd_serializer.sv */
// Bit-serial shifter that sends the valve bits out one per cycle.
`default_nettype none

module nvsrd_serializer import nvsrd_pkg::*; #(
    parameter int MAX_VALVES = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_load,
    input  wire t_count                i_count,
    input  wire logic [MAX_VALVES-1:0] i_bits,
    output t_ser_out                   o_ser
);

    logic                  r_active;
    logic [MAX_VALVES-1:0] r_shift;
    t_count                r_left;
    logic                  strobe;

    // r_left counts results due, this one included; 0 if count is 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_left   <= '0;
        end else if (i_load) begin
            r_active <= 1'b1;
            r_left   <= i_count;
        end else if (r_active) begin
            if (r_left <= t_count'(1)) begin
                r_active <= 1'b0;
            end else begin
                r_left <= r_left - t_count'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_shift <= i_bits;
        end else if (r_active) begin
            r_shift <= r_shift >> 1;
        end
    end

    // A zero count gives one latch-only result with no data.
    assign strobe             = r_left != '0;
    assign o_ser.valid        = r_active;
    assign o_ser.shift_bit    = r_active & strobe & r_shift[0];
    assign o_ser.shift_strobe = r_active & strobe;
    assign o_ser.latch_strobe = r_active & (r_left <= t_count'(1));
    assign o_ser.busy         = r_active;

endmodule

`default_nettype wire

/* rtl/core/nvsrd_checker.sv */
// Port-level checker for the note valve shift register driver, bound to the top.
`default_nettype none

module nvsrd_checker import nvsrd_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_start,
    input wire logic      o_busy,
    input wire t_req_type i_req_type,
    input wire logic      o_valid,
    input wire logic      o_shift_bit,
    input wire logic      o_shift_strobe,
    input wire logic      o_latch_strobe
);

    // Results appear only while the block reports busy.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy)
        else $error("result shown while not busy");

    // Result fields are quiet outside a result cycle.
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_shift_bit || o_shift_strobe || o_latch_strobe) |-> o_valid)
        else $error("result field active without a result");

    // An accepted push shows its first result in the next cycle.
    a_push_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_req_type == REQ_PUSH) |=> o_valid)
        else $error("push gave no result");

    // A push runs without gaps until its latch result.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_latch_strobe) |=> (o_valid && o_shift_strobe))
        else $error("gap inside a push");

    // The latch result ends the push.
    a_latch_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_latch_strobe) |=> !o_valid)
        else $error("result after the latch strobe");

endmodule

bind note_valve_shift_register_driver_core nvsrd_checker u_nvsrd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .i_req_type     (i_req_type),
    .o_valid        (o_valid),
    .o_shift_bit    (o_shift_bit),
    .o_shift_strobe (o_shift_strobe),
    .o_latch_strobe (o_latch_strobe)
);

`default_nettype wire
